// File: sv/mts_pkg.sv
`default_nettype none

package mts_pkg;

    // Default geometry of the two stacks
    localparam int StackDepthDefault = 128;
    localparam int WordBitsDefault   = 32;

    // Fixed payload widths of the channels
    localparam int DataBits   = 32;
    localparam int FillBits   = 8;
    localparam int StatusBits = 2;

    // Operation codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Status codes
    localparam logic [StatusBits-1:0] ST_OK         = 2'd0;
    localparam logic [StatusBits-1:0] ST_PUSH_FULL  = 2'd1;
    localparam logic [StatusBits-1:0] ST_POP_EMPTY  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // latch the item, read both stack tops
        logic step;        // commit stack writes and counts
        logic load_eval;   // load result straight from the evaluation
        logic load_fetch;  // load result with the refetched minimum
    } mts_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic refill;      // pop removed the minimum, next one must be read
    } mts_stat_t;

endpackage

`default_nettype wire

// File: sv/mts_op_if.sv
`default_nettype none

interface mts_op_if;
    import mts_pkg::*;

    logic                valid;
    logic                ready;
    logic                action;
    logic [DataBits-1:0] push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface

`default_nettype wire

// File: sv/mts_result_if.sv
`default_nettype none

interface mts_result_if;
    import mts_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DataBits-1:0]   popped_value;
    logic [DataBits-1:0]   current_minimum;
    logic [FillBits-1:0]   fill_count;
    logic [StatusBits-1:0] status;

    modport source (output valid, output popped_value, output current_minimum,
                    output fill_count, output status, input ready);
    modport sink   (input valid, input popped_value, input current_minimum,
                    input fill_count, input status, output ready);
endinterface

`default_nettype wire

// File: sv/min_tracking_stack_unit.sv
// Channel  Dir  Fields                                            Transfer
// op       in   action, push_value                                valid && ready
// result   out  popped_value, current_minimum, fill_count, status valid && ready
//
// An item is captured on transfer and evaluated from the stack tops, read
// through the registered read ports of the value and minimum stack RAMs;
// a pop that removes the current minimum while older minima remain also
// rereads the minimum stack. Reset clears both stack counts at once.
// A result waits in the output register while the next op is transferred.
`default_nettype none

module min_tracking_stack_unit #(
    parameter int STACK_DEPTH = mts_pkg::StackDepthDefault,
    parameter int WORD_BITS   = mts_pkg::WordBitsDefault
) (
    input wire logic     clk,
    input wire logic     rst_n,
    mts_op_if.sink       op,
    mts_result_if.source result
);
    import mts_pkg::*;

    mts_cmd_t  cmd;
    mts_stat_t stat;

    mts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (op.valid),
        .in_ready  (op.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mts_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_BITS   (WORD_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .action          (op.action),
        .push_value      (op.push_value),
        .popped_value    (result.popped_value),
        .current_minimum (result.current_minimum),
        .fill_count      (result.fill_count),
        .status          (result.status)
    );

endmodule

`default_nettype wire

// File: sv/mts_ram.sv
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/mts_ctrl.sv
`default_nettype none

module mts_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire mts_pkg::mts_stat_t stat,
    output mts_pkg::mts_cmd_t       cmd
);
    import mts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_FETCH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // Output register can take a new result when empty or being drained
    assign out_free = !out_valid_reg || out_ready;

    // Sequence one item: capture, evaluate, optional minimum refetch
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (stat.refill)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_FETCH;
                end
                else if (out_free)
                begin
                    cmd.step       = 1'b1;
                    cmd.load_eval  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_FETCH:
            begin
                if (out_free)
                begin
                    cmd.load_fetch = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: sv/mts_datapath.sv
`default_nettype none

module mts_datapath #(
    parameter int STACK_DEPTH = mts_pkg::StackDepthDefault,
    parameter int WORD_BITS   = mts_pkg::WordBitsDefault
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mts_pkg::mts_cmd_t                 cmd,
    output mts_pkg::mts_stat_t                     stat,
    input  wire logic                              action,
    input  wire logic [mts_pkg::DataBits-1:0]      push_value,
    output logic      [mts_pkg::DataBits-1:0]      popped_value,
    output logic      [mts_pkg::DataBits-1:0]      current_minimum,
    output logic      [mts_pkg::FillBits-1:0]      fill_count,
    output logic      [mts_pkg::StatusBits-1:0]    status
);
    import mts_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE_COUNT  = CW'(1);
    localparam logic [CW-1:0] TWO_COUNT  = CW'(2);

    // Item and stack state
    logic                  act_reg;
    logic [WORD_BITS-1:0]  val_reg;
    logic [CW-1:0]         vc_reg, vc_next;
    logic [CW-1:0]         mc_reg, mc_next;
    logic [DataBits-1:0]   res_pop_reg;
    logic [FillBits-1:0]   res_fill_reg;
    logic [StatusBits-1:0] res_stat_reg;

    // Result register
    logic [DataBits-1:0]   out_pop_reg;
    logic [DataBits-1:0]   out_min_reg;
    logic [FillBits-1:0]   out_fill_reg;
    logic [StatusBits-1:0] out_stat_reg;

    // RAM ports
    logic [WORD_BITS-1:0]  vtop, mtop;
    logic                  v_we, m_we, v_re, m_re;
    logic [AW-1:0]         v_raddr, m_raddr;
    logic [CW-1:0]         v_rcnt, m_rcnt;
    logic [2*DataBits-1:0] push_ext;
    logic [WORD_BITS-1:0]  push_word;

    // Evaluation
    logic                  is_push, is_pop, full, empty, mc_zero;
    logic                  push_ok, pop_ok, min_wr, pop_hit;
    logic [WORD_BITS-1:0]  eval_min;
    logic [StatusBits-1:0] eval_stat;
    logic [DataBits-1:0]   eval_pop;

    assign push_ext  = {{DataBits{1'b0}}, push_value};
    assign push_word = push_ext[WORD_BITS-1:0];

    assign is_push = (act_reg == ACT_PUSH);
    assign is_pop  = (act_reg == ACT_POP);
    assign full    = (vc_reg == FULL_COUNT);
    assign empty   = (vc_reg == '0);
    assign mc_zero = (mc_reg == '0);
    assign push_ok = is_push && !full;
    assign pop_ok  = is_pop && !empty;
    assign min_wr  = push_ok && (mc_reg != FULL_COUNT)
                     && (mc_zero || ($signed(val_reg) <= $signed(mtop)));
    assign pop_hit = pop_ok && !mc_zero && (mtop == vtop);

    assign stat.refill = pop_hit && (mc_reg > ONE_COUNT);

    // Work out the step's result
    always_comb
    begin
        vc_next   = vc_reg;
        mc_next   = mc_reg;
        eval_stat = ST_OK;
        eval_pop  = '0;
        eval_min  = mc_zero ? '0 : mtop;
        if (is_push)
        begin
            if (full)
            begin
                eval_stat = ST_PUSH_FULL;
            end
            else
            begin
                vc_next = vc_reg + ONE_COUNT;
                if (min_wr)
                begin
                    mc_next  = mc_reg + ONE_COUNT;
                    eval_min = val_reg;
                end
            end
        end
        else
        begin
            if (empty)
            begin
                eval_stat = ST_POP_EMPTY;
            end
            else
            begin
                vc_next  = vc_reg - ONE_COUNT;
                eval_pop = DataBits'($signed(vtop));
                if (pop_hit)
                begin
                    mc_next  = mc_reg - ONE_COUNT;
                    eval_min = '0;
                end
            end
        end
    end

    // Read addresses: tops on capture, the next minimum on a refill
    assign v_rcnt  = vc_reg - ONE_COUNT;
    assign m_rcnt  = cmd.capture ? (mc_reg - ONE_COUNT) : (mc_reg - TWO_COUNT);
    assign v_raddr = v_rcnt[AW-1:0];
    assign m_raddr = m_rcnt[AW-1:0];
    assign v_re    = cmd.capture;
    assign m_re    = cmd.capture || (cmd.step && stat.refill);
    assign v_we    = cmd.step && push_ok;
    assign m_we    = cmd.step && min_wr;

    mts_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (vc_reg[AW-1:0]),
        .wdata (val_reg),
        .re    (v_re),
        .raddr (v_raddr),
        .rdata (vtop)
    );

    mts_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_minimum_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (mc_reg[AW-1:0]),
        .wdata (val_reg),
        .re    (m_re),
        .raddr (m_raddr),
        .rdata (mtop)
    );

    // Advance the stack counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= '0;
            mc_reg <= '0;
        end
        else if (cmd.step)
        begin
            vc_reg <= vc_next;
            mc_reg <= mc_next;
        end
    end

    // Hold the item and the partial result, load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            val_reg <= push_word;
        end
        if (cmd.step)
        begin
            res_pop_reg  <= eval_pop;
            res_fill_reg <= FillBits'(vc_next);
            res_stat_reg <= eval_stat;
        end
        if (cmd.load_eval)
        begin
            out_pop_reg  <= eval_pop;
            out_min_reg  <= DataBits'($signed(eval_min));
            out_fill_reg <= FillBits'(vc_next);
            out_stat_reg <= eval_stat;
        end
        else if (cmd.load_fetch)
        begin
            out_pop_reg  <= res_pop_reg;
            out_min_reg  <= DataBits'($signed(mtop));
            out_fill_reg <= res_fill_reg;
            out_stat_reg <= res_stat_reg;
        end
    end

    assign popped_value    = out_pop_reg;
    assign current_minimum = out_min_reg;
    assign fill_count      = out_fill_reg;
    assign status          = out_stat_reg;

endmodule

`default_nettype wire
